>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the radix digit emitter RTL.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Consequent must hold in the cycle after the trigger.
`define RDE_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rde_pkg.sv
// Package for the radix digit emitter: item types, divider control types,
// radix limits and the digit-to-ASCII mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

	localparam int CNT_W = 7;   // digit count field width

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;

	localparam logic [6:0] CHAR_ZERO    = 7'h30;  // '0'
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;  // 'A'
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;  // 'a'

	typedef struct packed {
		logic [63:0] value;
		logic [4:0]  radix;
		logic        upper;
	} in_item_t;

	typedef struct packed {
		logic [6:0]       digit_char;
		logic [CNT_W-1:0] digit_count;
		logic             last_digit;
	} out_item_t;

	// Commands to the serial divider
	typedef struct packed {
		logic load;   // start on a new dividend
		logic next;   // divide the quotient just produced again
	} div_cmd_t;

	// Status from the serial divider
	typedef struct packed {
		logic       done;      // one-cycle pulse, digit valid
		logic       quot_nz;   // quotient left in place is nonzero
		logic [3:0] digit;     // remainder of this pass
	} div_stat_t;

	function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic up);
		logic [6:0] base_ch;
		base_ch = up ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < 4'd10)
			return CHAR_ZERO + {3'b000, d};
		else
			return base_ch + {3'b000, d} - 7'd10;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rde_stream_if.sv
// Valid/ready stream channel used on both sides of the radix digit emitter.
// Payload type is a parameter; item types come from rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rde_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/radix_digit_emitter.sv
// Radix digit emitter: 64-bit unsigned value to ASCII digits in base 2..16,
// most significant first, one digit transfer per result. A value is turned
// into digits by repeated bit-serial division by the radix: each pass yields
// one digit, least significant first, which goes onto a digit stack; once the
// quotient is zero the stack is popped one digit per cycle, unless the output
// stalls, into the output register. A new value is taken while the final
// digit still waits in the output register. A radix below 2 acts as 2, above
// 16 as 16, and value bits at and above VALUE_BITS are ignored.
// Depends on rde_pkg, rde_stream_if, rde_serial_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module radix_digit_emitter
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rde_stream_if.sink   num,
	rde_stream_if.source digit
);

	localparam int DEPTH = VALUE_BITS;   // base 2 gives the most digits

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t           st_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] left_q;
	logic             upper_q;
	logic [3:0]       stk_q [DEPTH];
	logic             ovld_q;
	out_item_t        odata_q;

	div_cmd_t  dcmd;
	div_stat_t dstat;
	logic      accept;
	logic      load_out;
	logic      push;
	logic [4:0] base_c;

	assign num.ready = (st_q == S_IDLE);
	assign accept    = num.valid && num.ready;
	assign push      = (st_q == S_DIV) && dstat.done;
	assign load_out  = (st_q == S_EMIT) && (!ovld_q || digit.ready);

	// Radix clamp into 2..16
	always_comb begin
		priority if (num.data.radix < RADIX_MIN)
			base_c = RADIX_MIN;
		else if (num.data.radix > RADIX_MAX)
			base_c = RADIX_MAX;
		else
			base_c = num.data.radix;
	end

	assign dcmd.load = accept;
	assign dcmd.next = push && dstat.quot_nz;

	rde_serial_div #(
		.W (VALUE_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dcmd),
		.load_value (num.data.value[VALUE_BITS-1:0]),
		.load_base  (base_c),
		.stat       (dstat)
	);

	// Sequencer and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
			left_q  <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= '0;
						st_q    <= S_DIV;
					end
				end
				S_DIV: begin
					if (dstat.done) begin
						count_q <= count_q + 1'b1;
						if (!dstat.quot_nz) begin
							left_q <= count_q + 1'b1;
							st_q   <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (load_out) begin
						left_q <= left_q - 1'b1;
						if (left_q == CNT_W'(1))
							st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Letter case of the item in flight
	always_ff @(posedge clk) begin
		if (accept)
			upper_q <= num.data.upper;
	end

	// Digit stack: push shifts up, pop shifts down, top of stack at entry 0
	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= dstat.digit;
			for (int i = 1; i < DEPTH; i++)
				stk_q[i] <= stk_q[i-1];
		end else if (load_out) begin
			for (int i = 0; i < DEPTH - 1; i++)
				stk_q[i] <= stk_q[i+1];
			stk_q[DEPTH-1] <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovld_q <= 1'b0;
		else if (load_out)
			ovld_q <= 1'b1;
		else if (digit.ready)
			ovld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			odata_q.digit_char  <= digit_to_char(stk_q[0], upper_q);
			odata_q.digit_count <= count_q;
			odata_q.last_digit  <= (left_q == CNT_W'(1));
		end
	end

	assign digit.valid = ovld_q;
	assign digit.data  = odata_q;

	`RDE_ASSERT(a_emit_has_digits, (st_q != S_EMIT) || (left_q != '0),
		"emit state with no digits left")
	`RDE_ASSERT(a_done_in_div, !dstat.done || (st_q == S_DIV),
		"divider finished outside the divide state")
	`RDE_ASSERT_NEXT(a_last_marked, load_out && (left_q == CNT_W'(1)),
		digit.data.last_digit && (st_q == S_IDLE),
		"final digit not marked or sequencer not back to idle")
	`RDE_ASSERT(a_count_range,
		!digit.valid || ((digit.data.digit_count != '0)
		&& (digit.data.digit_count <= CNT_W'(DEPTH))),
		"digit count out of range")

endmodule

`default_nettype wire

>>> hw/rtl/rde_serial_div.sv
// Bit-serial restoring divider by a small radix: one quotient bit per cycle,
// quotient kept in place so it can be divided again. Uses rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rde_serial_div
	import rde_pkg::*;
#(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire div_cmd_t     cmd,
	input  wire logic [W-1:0] load_value,
	input  wire logic [4:0]   load_base,
	output div_stat_t         stat
);

	localparam int BC_W = $clog2(W);

	logic [W-1:0]    v_q;
	logic [3:0]      rem_q;
	logic [4:0]      base_q;
	logic [BC_W-1:0] bcnt_q;
	logic            busy_q;
	logic            done_q;
	logic            qnz_q;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	logic [4:0] trial;
	logic       ge;
	logic [3:0] rem_d;

	assign trial = {rem_q, v_q[W-1]};
	assign ge    = (trial >= base_q);
	assign rem_d = ge ? 4'(trial - base_q) : trial[3:0];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (bcnt_q == '0);
			if (cmd.load || cmd.next)
				busy_q <= 1'b1;
			else if (busy_q && (bcnt_q == '0))
				busy_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.next) begin
			if (cmd.load) begin
				v_q    <= load_value;
				base_q <= load_base;
			end
			rem_q  <= '0;
			qnz_q  <= 1'b0;
			bcnt_q <= BC_W'(W - 1);
		end else if (busy_q) begin
			v_q    <= {v_q[W-2:0], ge};
			rem_q  <= rem_d;
			qnz_q  <= qnz_q | ge;
			bcnt_q <= bcnt_q - 1'b1;
		end
	end

	assign stat.done    = done_q;
	assign stat.quot_nz = qnz_q;
	assign stat.digit   = rem_q;

	`RDE_ASSERT(a_rem_below_base, !busy_q || ({1'b0, rem_q} < base_q),
		"divider remainder reached the base")
	`RDE_ASSERT(a_no_cmd_while_busy, !(busy_q && (cmd.load || cmd.next)),
		"divider restarted in the middle of a pass")

endmodule

`default_nettype wire

>>> test/tb_radix_digit_emitter.sv
// Self-checking testbench for radix_digit_emitter: a table of directed numbers,
// then random numbers under four handshake mixes, checked digit by digit.
// Depends on rde_pkg, rde_stream_if and the emitter RTL.
`timescale 1ns / 1ps

module tb_radix_digit_emitter
	import rde_pkg::*;
();

	localparam int          VALUE_BITS   = 64;
	localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);
	localparam int          MAX_DIGITS   = 64;
	localparam string       DIGIT_GLYPHS = "0123456789abcdef0123456789ABCDEF";
	localparam int          CYCLE_LIMIT  = 4_000_000;
	localparam int          RANDOM_PER_PHASE = 60;
	localparam int          NUM_DIRECTED = 25;

	typedef struct {
		logic [63:0] value;
		logic [4:0]  radix;
		logic        upper;
		string       shown;  // digits as printed; empty when predicted
	} directed_row_t;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{64'd0, 5'd10, 1'b0, "0"},
		'{64'd0, 5'd2, 1'b1, "0"},
		'{64'd0, 5'd31, 1'b0, "0"},
		'{64'd1, 5'd16, 1'b0, "1"},
		'{64'd15, 5'd16, 1'b0, "f"},
		'{64'd15, 5'd16, 1'b1, "F"},
		'{64'd2, 5'd2, 1'b0, "10"},
		'{64'd16, 5'd16, 1'b0, "10"},
		'{64'd1000, 5'd10, 1'b0, "1000"},
		'{64'd10, 5'd0, 1'b0, "1010"},      // radix below two acts as binary
		'{64'd10, 5'd1, 1'b1, "1010"},
		'{64'd255, 5'd17, 1'b0, "ff"},      // radix above sixteen acts as hex
		'{64'd255, 5'd31, 1'b1, "FF"},
		'{64'hABCDEF, 5'd16, 1'b0, "abcdef"},
		'{64'h0123_4567_89AB_CDEF, 5'd16, 1'b1, "123456789ABCDEF"},
		'{ALL_ONES, 5'd16, 1'b0, "ffffffffffffffff"},
		'{ALL_ONES, 5'd16, 1'b1, "FFFFFFFFFFFFFFFF"},
		'{ALL_ONES, 5'd10, 1'b0, "18446744073709551615"},
		'{ALL_ONES, 5'd2, 1'b0, ""},
		'{64'h8000_0000_0000_0000, 5'd2, 1'b1, ""},
		'{ALL_ONES, 5'd8, 1'b0, ""},
		'{ALL_ONES, 5'd3, 1'b1, ""},
		'{64'hFEDC_BA98_7654_3210, 5'd15, 1'b1, ""},
		'{64'd35, 5'd6, 1'b0, ""},
		'{64'd12345, 5'd7, 1'b1, ""}
	};

	logic clk = 1'b0;
	logic arst_n;

	rde_stream_if #(.T(in_item_t))  num_if ();
	rde_stream_if #(.T(out_item_t)) digit_if ();

	radix_digit_emitter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.digit  (digit_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	out_item_t   staged_digits [$];   // digits of the number being offered
	out_item_t   pending_digits [$];  // digits owed by accepted numbers
	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int          mismatch_count = 0;
	int          digits_checked = 0;
	int          numbers_sent   = 0;
	int unsigned cycle_count    = 0;

	// Digits of one number, most significant first, into the staging queue
	function automatic void convert_to_digits(input in_item_t it);
		logic [63:0] rest;
		logic [63:0] base;
		logic [4:0]  r;
		logic [3:0]  rev [MAX_DIGITS];
		int          n;
		int          k;
		int          glyph;
		out_item_t   d;
		rest = it.value & VALUE_MASK;
		r = it.radix;
		if (r < RADIX_MIN)
			r = RADIX_MIN;
		if (r > RADIX_MAX)
			r = RADIX_MAX;
		base = 64'(r);
		n = 0;
		do begin
			rev[n] = 4'(rest % base);
			rest = rest / base;
			n++;
		end while (rest != 64'd0 && n < MAX_DIGITS);
		for (k = 0; k < n; k++) begin
			glyph = int'(rev[n - 1 - k]) + (it.upper ? 16 : 0);
			d.digit_char  = 7'(DIGIT_GLYPHS[glyph]);
			d.digit_count = CNT_W'(n);
			d.last_digit  = (k == n - 1);
			staged_digits.push_back(d);
		end
	endfunction

	// Digits typed in as text
	function automatic void stage_literal(input string shown);
		int        n;
		out_item_t d;
		n = shown.len();
		for (int i = 0; i < n; i++) begin
			d.digit_char  = 7'(shown[i]);
			d.digit_count = CNT_W'(n);
			d.last_digit  = (i == n - 1);
			staged_digits.push_back(d);
		end
	endfunction

	// Mostly short values so that runs stay quick; some full width, some zero
	function automatic in_item_t make_random_number();
		in_item_t it;
		int       nbits;
		if ($urandom_range(99) < 85)
			nbits = $urandom_range(24, 1);
		else
			nbits = $urandom_range(64, 1);
		it.value = {$urandom(), $urandom()};
		if (nbits < 64)
			it.value = it.value & ((64'd1 << nbits) - 64'd1);
		if ($urandom_range(9) < 3)
			it.value[nbits - 1] = 1'b1;
		if ($urandom_range(19) == 0)
			it.value = '0;
		if ($urandom_range(9) == 0)
			it.radix = 5'($urandom_range(31, 0));
		else
			it.radix = 5'($urandom_range(16, 2));
		it.upper = 1'($urandom_range(1));
		return it;
	endfunction

	// Offer one number; valid stays high across back-to-back transfers
	task automatic send_number(input in_item_t it);
		if ($urandom_range(99) < src_idle_pct) begin
			num_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		num_if.valid <= 1'b1;
		num_if.data  <= it;
		do @(posedge clk); while (!num_if.ready);
		// transfer took place at this edge
		foreach (staged_digits[i])
			pending_digits.push_back(staged_digits[i]);
		staged_digits.delete();
		numbers_sent++;
	endtask

	task automatic check_digit(input out_item_t got);
		out_item_t want;
		if (pending_digits.size() == 0) begin
			$error("unexpected digit transfer: char %0d count %0d last %0d",
				got.digit_char, got.digit_count, got.last_digit);
			mismatch_count++;
		end else begin
			want = pending_digits.pop_front();
			digits_checked++;
			if (got.digit_char !== want.digit_char) begin
				$error("digit_char: expected %0d, got %0d", want.digit_char, got.digit_char);
				mismatch_count++;
			end
			if (got.digit_count !== want.digit_count) begin
				$error("digit_count: expected %0d, got %0d", want.digit_count,
					got.digit_count);
				mismatch_count++;
			end
			if (got.last_digit !== want.last_digit) begin
				$error("last_digit: expected %0d, got %0d", want.last_digit, got.last_digit);
				mismatch_count++;
			end
		end
	endtask

	// Digit side: check each transfer, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			digit_if.ready <= 1'b0;
		end else begin
			if (digit_if.valid && digit_if.ready)
				check_digit(digit_if.data);
			digit_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d digits still owed", cycle_count,
			pending_digits.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		in_item_t it;
		int       src_mix [4];
		int       sink_mix [4];
		src_mix        = '{0, 61, 0, 32};
		sink_mix       = '{0, 0, 61, 32};
		arst_n         <= 1'b0;
		num_if.valid   <= 1'b0;
		num_if.data    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			it.value = directed_rows[i].value;
			it.radix = directed_rows[i].radix;
			it.upper = directed_rows[i].upper;
			if (directed_rows[i].shown.len() > 0)
				stage_literal(directed_rows[i].shown);
			else
				convert_to_digits(it);
			send_number(it);
		end

		// random numbers, one handshake mix per phase
		for (int p = 0; p < 4; p++) begin
			src_idle_pct   = src_mix[p];
			sink_stall_pct = sink_mix[p];
			repeat (RANDOM_PER_PHASE) begin
				it = make_random_number();
				convert_to_digits(it);
				send_number(it);
			end
		end
		num_if.valid <= 1'b0;

		// drain, then watch for stray digits
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d numbers converted (%0d from the table), %0d digit transfers checked,",
			numbers_sent, NUM_DIRECTED, digits_checked);
		$display("bases 2-16 plus clamped radix codes, under four sender/receiver idle mixes");
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> radix_digit_emitter.f
+incdir+hw/rtl
hw/rtl/rde_pkg.sv
hw/rtl/rde_stream_if.sv
hw/rtl/rde_serial_div.sv
hw/rtl/radix_digit_emitter.sv
test/tb_radix_digit_emitter.sv
